FILE: design/pid_tracking_settle_loop_assert.svh
// ----------------------------------------------------------------------------
// pid tracking settle loop assertion macros
// shorthand for clocked implication checks, reset gated on rst_ni
// ----------------------------------------------------------------------------
`ifndef PID_TRACKING_SETTLE_LOOP_ASSERT_SVH
`define PID_TRACKING_SETTLE_LOOP_ASSERT_SVH

// same-cycle implication
`define PTSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptsl: same-cycle check failed");

// next-cycle implication
`define PTSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptsl: next-cycle check failed");

`endif

FILE: design/ptsl_pkg.sv
// ----------------------------------------------------------------------------
// ptsl_pkg
// shared widths, register indexes, control word layout and microprogram
// ----------------------------------------------------------------------------
package ptsl_pkg;

  localparam int WINDOW_LEN = 10;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);

  localparam int OFS_W      = 11;
  localparam int ERR_W      = 12;
  localparam int DIF_W      = 13;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int YAW_W      = 17;
  localparam int BAND_W     = 8;
  localparam int DEG_W      = 8;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = GAIN_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PC_W       = 3;

  localparam logic signed [ACC_W-1:0] YAW_HI = ACC_W'(2**(YAW_W-1) - 1);
  localparam logic signed [ACC_W-1:0] YAW_LO = ACC_W'(-(2**(YAW_W-1)));

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_UPPER = 3'd6;

  localparam logic [GAIN_W-1:0] KP_RESET        = 16'd256;
  localparam logic [BAND_W-1:0] BAND_RESET      = 8'd6;
  localparam logic [DEG_W-1:0]  YAW_UPPER_RESET = 8'd60;

  // program steps
  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_PREP  = 3'd1;
  localparam logic [PC_W-1:0] PC_MUL_P = 3'd2;
  localparam logic [PC_W-1:0] PC_MUL_I = 3'd3;
  localparam logic [PC_W-1:0] PC_MUL_D = 3'd4;
  localparam logic [PC_W-1:0] PC_YAW   = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;

  typedef enum logic [1:0] {
    MSEL_KP,
    MSEL_KI,
    MSEL_KD
  } msel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_NO_UPD,
    JMP_WAIT_OUT
  } jmp_e;

  typedef struct packed {
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            prep;
    logic            mul_en;
    msel_e           msel;
    logic            acc_yaw;
    logic            acc_add;
    logic            yaw_wr;
    logic            emit;
  } uword_t;

  typedef struct packed {
    logic              enable;
    logic [OFS_W-1:0]  setpoint;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [BAND_W-1:0] band;
    logic [DEG_W-1:0]  yaw_upper;
  } cfg_t;

  typedef struct packed {
    logic in_fire;
    logic upd;
    logic out_free;
  } status_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      PC_IDLE: begin
        w.jmp = JMP_WAIT_IN;
      end
      PC_PREP: begin
        w.prep   = 1'b1;
        w.jmp    = JMP_NO_UPD;
        w.target = PC_EMIT;
      end
      PC_MUL_P: begin
        w.mul_en  = 1'b1;
        w.msel    = MSEL_KP;
        w.acc_yaw = 1'b1;
      end
      PC_MUL_I: begin
        w.mul_en  = 1'b1;
        w.msel    = MSEL_KI;
        w.acc_add = 1'b1;
      end
      PC_MUL_D: begin
        w.mul_en  = 1'b1;
        w.msel    = MSEL_KD;
        w.acc_add = 1'b1;
      end
      PC_YAW: begin
        w.yaw_wr = 1'b1;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_WAIT_OUT;
        w.target = PC_IDLE;
      end
      default: begin
        w.jmp    = JMP_WAIT_OUT;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/ptsl_cfg.sv
// ----------------------------------------------------------------------------
// ptsl_cfg
// configuration register file, written one word at a time by index
// ----------------------------------------------------------------------------
module ptsl_cfg import ptsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable:    1'b0,
                 setpoint:  '0,
                 kp:        KP_RESET,
                 ki:        '0,
                 kd:        '0,
                 band:      BAND_RESET,
                 yaw_upper: YAW_UPPER_RESET};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ENABLE:    cfg_q.enable    <= cfg_data_i[0];
        REG_SETPOINT:  cfg_q.setpoint  <= cfg_data_i[OFS_W-1:0];
        REG_KP:        cfg_q.kp        <= cfg_data_i[GAIN_W-1:0];
        REG_KI:        cfg_q.ki        <= cfg_data_i[GAIN_W-1:0];
        REG_KD:        cfg_q.kd        <= cfg_data_i[GAIN_W-1:0];
        REG_BAND:      cfg_q.band      <= cfg_data_i[BAND_W-1:0];
        REG_YAW_UPPER: cfg_q.yaw_upper <= cfg_data_i[DEG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/ptsl_seq.sv
// ----------------------------------------------------------------------------
// ptsl_seq
// step counter over the microprogram rom, with wait and skip jumps
// ----------------------------------------------------------------------------
module ptsl_seq import ptsl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output uword_t  ctrl_o,
  output logic    idle_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          w;

  always_comb begin
    w = ucode(pc_q);
    case (w.jmp)
      JMP_NEXT:     pc_d = pc_q + PC_W'(1);
      JMP_WAIT_IN:  pc_d = status_i.in_fire ? pc_q + PC_W'(1) : pc_q;
      JMP_NO_UPD:   pc_d = status_i.upd ? pc_q + PC_W'(1) : w.target;
      JMP_WAIT_OUT: pc_d = status_i.out_free ? w.target : pc_q;
      default:      pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = w;
  assign idle_o = (pc_q == PC_IDLE);

endmodule

FILE: design/ptsl_datapath.sv
// ----------------------------------------------------------------------------
// ptsl_datapath
// loop state, shared gain multiplier, accumulator, offset window and
// output register, all driven by the control word
// ----------------------------------------------------------------------------
module ptsl_datapath import ptsl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  uword_t                  ctrl_i,
  input  cfg_t                    cfg_i,
  input  logic                    in_fire_i,
  input  logic signed [OFS_W-1:0] offset_i,
  input  logic                    target_seen_i,
  input  logic                    rearm_i,
  input  logic                    out_stall_i,
  output status_t                 status_o,
  output logic                    out_valid_o,
  output logic signed [YAW_W-1:0] yaw_command_o,
  output logic                    updated_o,
  output logic                    settled_o
);

  logic signed [OFS_W-1:0]  ofs_q;
  logic                     seen_q;
  logic                     settled_q;
  logic                     updated_q;
  logic signed [YAW_W-1:0]  yaw_q;
  logic signed [SUM_W-1:0]  esum_q;
  logic signed [ERR_W-1:0]  last_q, prior_q, err_q;
  logic signed [DIF_W-1:0]  dif_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [OFS_W-1:0]         win_q [WINDOW_LEN];
  logic [SLOT_W-1:0]        slot_q;
  logic                     out_valid_q;
  logic signed [YAW_W-1:0]  out_yaw_q;
  logic                     out_upd_q, out_set_q;

  logic                     upd, do_prep, out_free;
  logic signed [ERR_W-1:0]  err;
  logic                     clr_int;
  logic [SUM_W-1:0]         sum_base, sum_sat;
  logic [SUM_W:0]           sum_w;
  logic [SLOT_W-1:0]        wslot;
  logic signed [ERR_W-1:0]  band_lo, band_hi;
  logic [WINDOW_LEN-1:0]    in_band;
  logic                     all_in;
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  prod_x, yaw_sum, yaw_sat;

  assign upd     = cfg_i.enable && seen_q && !settled_q;
  assign do_prep = ctrl_i.prep && upd;

  assign err = {cfg_i.setpoint[OFS_W-1], cfg_i.setpoint} - {ofs_q[OFS_W-1], ofs_q};

  // integral cleared when yaw is at or past the upper limit, or not above zero
  assign clr_int = (yaw_q >= $signed({1'b0, cfg_i.yaw_upper, 8'd0}))
                   || yaw_q[YAW_W-1] || (yaw_q == '0);
  assign sum_base = clr_int ? '0 : esum_q;
  assign sum_w    = {sum_base[SUM_W-1], sum_base}
                    + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
  always_comb begin
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      sum_sat = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_w[SUM_W-1:0];
    end
  end

  // slot out of range counts as zero
  assign wslot = ({1'b0, slot_q} < (SLOT_W+1)'(WINDOW_LEN)) ? slot_q : '0;

  assign band_lo = {cfg_i.setpoint[OFS_W-1], cfg_i.setpoint}
                   - {{(ERR_W-BAND_W){1'b0}}, cfg_i.band};
  assign band_hi = {cfg_i.setpoint[OFS_W-1], cfg_i.setpoint}
                   + {{(ERR_W-BAND_W){1'b0}}, cfg_i.band};

  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      in_band[i] = ($signed({win_q[i][OFS_W-1], win_q[i]}) >= band_lo)
                   && ($signed({win_q[i][OFS_W-1], win_q[i]}) <= band_hi);
    end
  end
  assign all_in = &in_band;

  always_comb begin
    case (ctrl_i.msel)
      MSEL_KP: begin
        mul_a = cfg_i.kp;
        mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      MSEL_KI: begin
        mul_a = cfg_i.ki;
        mul_b = esum_q;
      end
      MSEL_KD: begin
        mul_a = cfg_i.kd;
        mul_b = {{(MUL_B_W-DIF_W){dif_q[DIF_W-1]}}, dif_q};
      end
      default: begin
        mul_a = cfg_i.kp;
        mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
    endcase
  end

  assign prod_x  = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign yaw_sum = acc_q + prod_x;
  always_comb begin
    if (yaw_sum > YAW_HI) begin
      yaw_sat = YAW_HI;
    end else if (yaw_sum < YAW_LO) begin
      yaw_sat = YAW_LO;
    end else begin
      yaw_sat = yaw_sum;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      settled_q   <= 1'b0;
      updated_q   <= 1'b0;
      yaw_q       <= '0;
      esum_q      <= '0;
      last_q      <= '0;
      prior_q     <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (in_fire_i) begin
        seen_q <= target_seen_i;
      end
      // rearm acts on acceptance, ahead of this tick's update
      if (in_fire_i && rearm_i) begin
        settled_q <= 1'b0;
      end else if (ctrl_i.yaw_wr && all_in) begin
        settled_q <= 1'b1;
      end
      if (ctrl_i.prep) begin
        updated_q <= upd;
      end
      if (do_prep) begin
        esum_q        <= sum_sat;
        prior_q       <= last_q;
        last_q        <= err;
        win_q[wslot]  <= ofs_q;
        slot_q        <= (wslot == SLOT_W'(WINDOW_LEN-1)) ? '0 : wslot + SLOT_W'(1);
      end
      if (ctrl_i.yaw_wr) begin
        yaw_q <= yaw_sat[YAW_W-1:0];
      end
      if (ctrl_i.emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      ofs_q <= offset_i;
    end
    if (do_prep) begin
      err_q <= err;
      dif_q <= {last_q[ERR_W-1], last_q} - {prior_q[ERR_W-1], prior_q};
    end
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctrl_i.acc_yaw) begin
      acc_q <= {{(ACC_W-YAW_W){yaw_q[YAW_W-1]}}, yaw_q};
    end else if (ctrl_i.acc_add) begin
      acc_q <= acc_q + prod_x;
    end
    if (ctrl_i.emit && out_free) begin
      out_yaw_q <= yaw_q;
      out_upd_q <= updated_q;
      out_set_q <= settled_q;
    end
  end

  assign status_o      = '{in_fire: in_fire_i, upd: upd, out_free: out_free};
  assign out_valid_o   = out_valid_q;
  assign yaw_command_o = out_yaw_q;
  assign updated_o     = out_upd_q;
  assign settled_o     = out_set_q;

endmodule

FILE: design/pid_tracking_settle_loop.sv
// ----------------------------------------------------------------------------
// pid_tracking_settle_loop
// pid yaw loop that adds the gain terms to the last yaw, with an offset window settle detector
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_stall_o   offset, target_seen, rearm
//   out      source     out_valid_o / out_stall_i yaw_command, updated, settled
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a tick that runs the update goes prep, mul_p, mul_i, mul_d, yaw, emit;
// one that does not goes prep, emit; the three gain products go in turn
// through one 16x32 multiplier under the microprogram.
// reset clears loop state, the offset window and the registers to defaults.
// a result waiting on out_stall_i holds the sequencer at its last step only.
// ----------------------------------------------------------------------------
module pid_tracking_settle_loop import ptsl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [OFS_W-1:0] offset_i,
  input  logic                    target_seen_i,
  input  logic                    rearm_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [YAW_W-1:0] yaw_command_o,
  output logic                    updated_o,
  output logic                    settled_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  cfg_t    cfg;
  uword_t  ctrl;
  status_t status;
  logic    idle;
  logic    in_fire;

  assign in_stall_o = !idle;
  assign in_fire    = in_valid_i && !in_stall_o;

  ptsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ptsl_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .idle_o   (idle)
  );

  ptsl_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg),
    .in_fire_i     (in_fire),
    .offset_i      (offset_i),
    .target_seen_i (target_seen_i),
    .rearm_i       (rearm_i),
    .out_stall_i   (out_stall_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .yaw_command_o (yaw_command_o),
    .updated_o     (updated_o),
    .settled_o     (settled_o)
  );

endmodule

FILE: design/ptsl_checker.sv
// ----------------------------------------------------------------------------
// ptsl_checker
// port-level checks on the tracking loop, bound to the top level
// ----------------------------------------------------------------------------
`include "pid_tracking_settle_loop_assert.svh"

module ptsl_checker import ptsl_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [YAW_W-1:0] yaw_command_o
);

  // a stalled result stays
  `PTSL_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `PTSL_ASSERT_NXT(a_yaw_hold, out_valid_o && out_stall_i, $stable(yaw_command_o))
  // one word in flight: busy right after acceptance
  `PTSL_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // a fresh result frees the input side
  `PTSL_ASSERT_IMP(a_free_on_result, $rose(out_valid_o), !in_stall_o)

endmodule

bind pid_tracking_settle_loop ptsl_checker u_ptsl_checker (.*);
